FILE: sv/wfs_pkg.sv
package wfs_pkg;

  localparam int MaxWindow = 64;
  localparam int SlotW     = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int FillW     = $clog2(MaxWindow + 1);
  localparam int CfgW      = 7;
  localparam int HashW     = 32;
  localparam int PosW      = 32;

  typedef struct packed {
    logic signed [HashW-1:0] hash;
    logic                    last;
  } wfs_in_t;

  typedef struct packed {
    logic signed [HashW-1:0] fingerprint_hash;
    logic [PosW-1:0]         fingerprint_position;
  } wfs_out_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } wfs_cmp_t;

  function automatic logic [FillW-1:0] eff_window(input logic [CfgW-1:0] ws);
    logic [FillW-1:0] w;
    if (ws == '0) begin
      w = FillW'(1);
    end else if (int'(ws) > MaxWindow) begin
      w = FillW'(MaxWindow);
    end else begin
      w = FillW'(ws);
    end
    return w;
  endfunction

endpackage

FILE: sv/wfs_ram.sv
module wfs_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  logic [Width-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/wfs_cmp_unit.sv
module wfs_cmp_unit (
  input  logic signed [wfs_pkg::HashW-1:0] a_i,
  input  logic signed [wfs_pkg::HashW-1:0] b_i,
  output wfs_pkg::wfs_cmp_t                res_o
);

  assign res_o.lt = (a_i < b_i);
  assign res_o.eq = (a_i == b_i);

endmodule

FILE: sv/winnowing_fingerprint_selector_core.sv
// Winnowing fingerprint selector: sliding-window minimum over a hash stream.
// Input channel (in_valid_i/in_ready_o, in_data_i): one hash item, with last
// marking the end of a stream. Output channel (out_valid_o/out_ready_i,
// out_data_o): zero or one fingerprint per input item, with its 1-based
// stream position.
// For most items the result appears in the output register the cycle after
// acceptance. An item that pushes the current minimum out of the window
// starts a rescan of the older ring memory entries, newest to oldest, each
// in StRead then StCmp (registered RAM read, then compare).
// One comparator is shared by the insert and the rescan steps.
// in_ready_o is low during a rescan and while an unread result is stalled
// by the receiver; a waiting result holds its value until taken.
// Reset leaves the window size at 4 and the stream empty; a cfg write sets
// the window size and empties the stream. The ring memory is not cleared:
// only entries written in the current stream are read.
module winnowing_fingerprint_selector_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [wfs_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  wfs_pkg::wfs_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output wfs_pkg::wfs_out_t         out_data_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StCmp  = 2'd2;

  localparam int SlotW = wfs_pkg::SlotW;
  localparam int FillW = wfs_pkg::FillW;
  localparam int PosW  = wfs_pkg::PosW;
  localparam int HashW = wfs_pkg::HashW;

  logic [1:0]              state_q, state_d;
  logic [wfs_pkg::CfgW-1:0] ws_q, ws_d;
  logic [SlotW-1:0]        newest_q, newest_d;
  logic [SlotW-1:0]        min_slot_q, min_slot_d;
  logic [PosW-1:0]         min_pos_q, min_pos_d;
  logic signed [HashW-1:0] min_hash_q, min_hash_d;
  logic [FillW-1:0]        fill_q, fill_d;
  logic [PosW-1:0]         items_q, items_d;
  logic [SlotW-1:0]        scan_slot_q, scan_slot_d;
  logic [SlotW-1:0]        scan_age_q, scan_age_d;
  logic [SlotW-1:0]        best_age_q, best_age_d;
  logic                    last_q, last_d;
  logic                    out_valid_q, out_valid_d;
  wfs_pkg::wfs_out_t       out_data_q, out_data_d;

  logic [FillW-1:0]        w_eff;
  logic [SlotW-1:0]        w_m1;
  logic                    accept;
  logic [PosW-1:0]         items_nx;
  logic [SlotW-1:0]        slot;
  logic                    in_fill;
  logic                    ram_we;
  logic                    ram_re;
  logic signed [HashW-1:0] ram_rdata;
  logic signed [HashW-1:0] cmp_a;
  wfs_pkg::wfs_cmp_t       cmp_res;
  logic                    emit;
  logic                    clear;
  logic [SlotW-1:0]        age_fin;

  assign w_eff    = wfs_pkg::eff_window(ws_q);
  assign w_m1     = SlotW'(w_eff - FillW'(1));
  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign accept   = in_valid_i && in_ready_o;
  assign items_nx = (items_q == '1) ? items_q : items_q + PosW'(1);
  assign in_fill  = (fill_q < w_eff);
  assign slot     = in_fill ? fill_q[SlotW-1:0]
                            : ((newest_q == w_m1) ? '0 : newest_q + SlotW'(1));
  assign ram_we   = accept;
  assign ram_re   = (state_q == StRead);
  assign cmp_a    = (state_q == StCmp) ? ram_rdata : in_data_i.hash;

  wfs_ram #(
    .Width (HashW),
    .Depth (wfs_pkg::MaxWindow)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot),
    .wdata_i (in_data_i.hash),
    .re_i    (ram_re),
    .raddr_i (scan_slot_q),
    .rdata_o (ram_rdata)
  );

  wfs_cmp_unit u_cmp (
    .a_i   (cmp_a),
    .b_i   (min_hash_q),
    .res_o (cmp_res)
  );

  always_comb begin
    state_d     = state_q;
    ws_d        = ws_q;
    newest_d    = newest_q;
    min_slot_d  = min_slot_q;
    min_pos_d   = min_pos_q;
    min_hash_d  = min_hash_q;
    fill_d      = fill_q;
    items_d     = items_q;
    scan_slot_d = scan_slot_q;
    scan_age_d  = scan_age_q;
    best_age_d  = best_age_q;
    last_d      = last_q;
    emit        = 1'b0;
    clear       = 1'b0;
    age_fin     = best_age_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          items_d  = items_nx;
          newest_d = slot;
          clear    = in_data_i.last;
          if (in_fill) begin
            if (fill_q == '0 || cmp_res.lt || cmp_res.eq) begin
              min_slot_d = slot;
              min_pos_d  = items_nx;
              min_hash_d = in_data_i.hash;
            end
            fill_d = fill_q + FillW'(1);
            emit   = (fill_d == w_eff) || in_data_i.last;
          end else if (min_slot_q == slot) begin
            min_slot_d = slot;
            min_hash_d = in_data_i.hash;
            min_pos_d  = items_nx;
            if (w_m1 == '0) begin
              emit = 1'b1;
            end else begin
              // minimum left the window: rescan older entries
              clear       = 1'b0;
              best_age_d  = '0;
              scan_slot_d = (slot == '0) ? w_m1 : slot - SlotW'(1);
              scan_age_d  = SlotW'(1);
              last_d      = in_data_i.last;
              state_d     = StRead;
            end
          end else if (cmp_res.lt) begin
            min_slot_d = slot;
            min_pos_d  = items_nx;
            min_hash_d = in_data_i.hash;
            emit       = 1'b1;
          end
        end
      end
      StRead: begin
        state_d = StCmp;
      end
      StCmp: begin
        if (cmp_res.lt) begin
          min_hash_d = ram_rdata;
          min_slot_d = scan_slot_q;
          best_age_d = scan_age_q;
          age_fin    = scan_age_q;
        end
        if (scan_age_q == w_m1) begin
          min_pos_d = items_q - PosW'(age_fin);
          emit      = 1'b1;
          clear     = last_q;
          state_d   = StIdle;
        end else begin
          scan_slot_d = (scan_slot_q == '0) ? w_m1 : scan_slot_q - SlotW'(1);
          scan_age_d  = scan_age_q + SlotW'(1);
          state_d     = StRead;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (cfg_we_i) begin
      ws_d  = cfg_wdata_i;
      clear = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if (emit) begin
      out_valid_d                     = 1'b1;
      out_data_d.fingerprint_hash     = min_hash_d;
      out_data_d.fingerprint_position = min_pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ws_q        <= wfs_pkg::CfgW'(4);
      newest_q    <= '0;
      min_slot_q  <= '0;
      min_pos_q   <= '0;
      fill_q      <= '0;
      items_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ws_q        <= ws_d;
      out_valid_q <= out_valid_d;
      if (clear) begin
        newest_q   <= '0;
        min_slot_q <= '0;
        min_pos_q  <= '0;
        fill_q     <= '0;
        items_q    <= '0;
      end else begin
        newest_q   <= newest_d;
        min_slot_q <= min_slot_d;
        min_pos_q  <= min_pos_d;
        fill_q     <= fill_d;
        items_q    <= items_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    min_hash_q  <= min_hash_d;
    scan_slot_q <= scan_slot_d;
    scan_age_q  <= scan_age_d;
    best_age_q  <= best_age_d;
    last_q      <= last_d;
    out_data_q  <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: sv/wfs_checker.sv
module wfs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input wfs_pkg::wfs_out_t out_data_o
);

  // stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output item changed");

  // no new item taken while a result is stuck
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  // positions are 1-based
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.fingerprint_position != '0)
    else $error("zero fingerprint position");

  // a result only follows an accepted item or a running rescan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o) || $past(in_valid_i))
    else $error("output item without cause");

endmodule

bind winnowing_fingerprint_selector_core wfs_checker u_wfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
